[rtl/core/rsq_pkg.sv]
// ----------------------------------------------------------------------------
// Range sample qualifier package
// Shared widths, status codes, register indexes and constants.
// ----------------------------------------------------------------------------
package rsq_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned StaleW = 24;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  typedef logic [DistW-1:0]  dist_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [StaleW-1:0] stale_t;
  typedef logic [ByteW-1:0]  byte_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_STALE     = 2'd2,
    ST_INVALID   = 2'd3
  } rsq_status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DIST  = 2'd0,
    CFG_MAX_DIST  = 2'd1,
    CFG_STALE_LIM = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // Device status codes that carry a usable distance
  localparam logic [3:0] DevStatusGood   = 4'd11;
  localparam logic [3:0] DevStatusSigma  = 4'd8;
  localparam logic [3:0] DevStatusWrap   = 4'd10;

  localparam logic [2:0] IrqNewMask      = 3'h7;
  localparam dist_t      OutOfRangeMm    = 16'd8190;
  localparam stale_t     StaleResetUs    = 24'd1000000;

endpackage

[rtl/core/rsq_in_if.sv]
// ----------------------------------------------------------------------------
// Poll input channel
// Valid/ready channel carrying one sensor poll per beat.
// ----------------------------------------------------------------------------
interface rsq_in_if;
  logic                valid;
  logic                ready;
  logic                init_done;
  rsq_pkg::byte_t      irq_status;
  rsq_pkg::byte_t      range_status;
  rsq_pkg::dist_t      raw_distance;
  rsq_pkg::time_t      now_us;

  modport source (output valid, init_done, irq_status, range_status, raw_distance,
                  now_us, input ready);
  modport sink   (input valid, init_done, irq_status, range_status, raw_distance,
                  now_us, output ready);
endinterface

[rtl/core/rsq_out_if.sv]
// ----------------------------------------------------------------------------
// Qualified result channel
// Valid/ready channel carrying one qualified distance per beat.
// ----------------------------------------------------------------------------
interface rsq_out_if;
  logic                valid;
  logic                ready;
  rsq_pkg::dist_t      distance_mm;
  logic [1:0]          status;
  logic                need_init;

  modport source (output valid, distance_mm, status, need_init, input ready);
  modport sink   (input valid, distance_mm, status, need_init, output ready);
endinterface

[rtl/core/rsq_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface rsq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rsq_pkg::CfgIdxW-1:0]     index;
  logic [rsq_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/range_sample_qualifier_unit.sv]
// ----------------------------------------------------------------------------
// Range sample qualifier
// Qualifies each ranging sensor poll, clamps and caches the distance.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register. Throughput: one poll per
// cycle while the result channel is not stalled; the qualifier state is updated
// as a poll moves from the input register to the result register.
// Reset (rst_n low, synchronous): both stages empty, flags and cache cleared,
// limits disabled, stale limit 1000000 us.
module range_sample_qualifier_unit (
  input  logic clk,
  input  logic rst_n,
  rsq_in_if.sink    in_ch,
  rsq_out_if.source out_ch,
  rsq_cfg_if.sink   cfg_ch
);
  import rsq_pkg::*;

  // Configuration registers
  dist_t  min_dist_r;
  dist_t  max_dist_r;
  stale_t stale_lim_r;

  // Input stage
  logic   s1_valid_r;
  logic   s1_init_done_r;
  byte_t  s1_irq_r;
  byte_t  s1_rstat_r;
  dist_t  s1_raw_r;
  time_t  s1_now_r;

  // Qualifier state
  logic   init_flag_r, init_flag_nxt;
  logic   has_sample_r, has_sample_nxt;
  dist_t  last_dist_r, last_dist_nxt;
  time_t  last_time_r, last_time_nxt;

  // Result stage
  logic        out_valid_r;
  dist_t       out_dist_r, out_dist_nxt;
  rsq_status_t out_status_r, out_status_nxt;
  logic        out_need_init_r;

  logic   out_space;
  logic   advance;
  logic   in_fire;
  logic   init_eff;
  logic   has_eff;
  logic   new_sample;
  logic   dev_ok;
  logic [3:0] dev_status;
  dist_t  pick_mm;
  dist_t  lo_mm;
  dist_t  clamp_mm;
  time_t  age_us;
  logic   stale;

  // The result register frees when empty or when its beat is taken
  assign out_space = !out_valid_r || out_ch.ready;
  assign advance   = s1_valid_r && out_space;
  assign in_ch.ready = !s1_valid_r || out_space;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Device status and clamp
  assign dev_status = s1_rstat_r[6:3];
  assign dev_ok     = (dev_status == DevStatusGood) || (dev_status == DevStatusSigma) ||
                      (dev_status == DevStatusWrap);
  assign pick_mm    = dev_ok ? s1_raw_r : OutOfRangeMm;
  // Minimum first, then maximum, so a crossed maximum wins
  assign lo_mm      = ((min_dist_r != '0) && (pick_mm < min_dist_r)) ? min_dist_r : pick_mm;
  assign clamp_mm   = ((max_dist_r != '0) && (lo_mm > max_dist_r)) ? max_dist_r : lo_mm;

  // Age of cached sample wraps with the timestamp counter
  assign age_us     = s1_now_r - last_time_r;
  assign stale      = age_us > {{(TimeW-StaleW){1'b0}}, stale_lim_r};

  assign new_sample = (s1_irq_r[2:0] & IrqNewMask) != '0;
  // Init done sets the flag and drops the cache before the poll is judged
  assign init_eff   = s1_init_done_r || init_flag_r;
  assign has_eff    = s1_init_done_r ? 1'b0 : has_sample_r;

  always_comb begin
    init_flag_nxt  = init_eff;
    has_sample_nxt = has_eff;
    last_dist_nxt  = last_dist_r;
    last_time_nxt  = last_time_r;
    out_dist_nxt   = '0;
    out_status_nxt = ST_OK;
    if (!init_eff) begin
      out_status_nxt = ST_NOT_READY;
    end else if (new_sample) begin
      if (s1_raw_r == '0) begin
        // Zero distance: keep the cache, stay initialised only if it holds a sample
        init_flag_nxt  = has_eff;
        out_status_nxt = ST_INVALID;
      end else begin
        last_dist_nxt  = clamp_mm;
        last_time_nxt  = s1_now_r;
        has_sample_nxt = 1'b1;
        out_dist_nxt   = clamp_mm;
      end
    end else if (!has_eff) begin
      out_status_nxt = ST_NOT_READY;
    end else if (stale) begin
      // Stale cache: drop both flags and ask for re-initialisation
      init_flag_nxt  = 1'b0;
      has_sample_nxt = 1'b0;
      out_status_nxt = ST_STALE;
    end else begin
      out_dist_nxt   = last_dist_r;
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r  <= '0;
      max_dist_r  <= '0;
      stale_lim_r <= StaleResetUs;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_MIN_DIST:  min_dist_r  <= cfg_ch.data[DistW-1:0];
        CFG_MAX_DIST:  max_dist_r  <= cfg_ch.data[DistW-1:0];
        CFG_STALE_LIM: stale_lim_r <= cfg_ch.data[StaleW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Input stage payload: load on every accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_init_done_r <= in_ch.init_done;
      s1_irq_r       <= in_ch.irq_status;
      s1_rstat_r     <= in_ch.range_status;
      s1_raw_r       <= in_ch.raw_distance;
      s1_now_r       <= in_ch.now_us;
    end
  end

  // Qualifier state advances with each poll that moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_flag_r  <= 1'b0;
      has_sample_r <= 1'b0;
      last_dist_r  <= '0;
      last_time_r  <= '0;
    end else if (advance) begin
      init_flag_r  <= init_flag_nxt;
      has_sample_r <= has_sample_nxt;
      last_dist_r  <= last_dist_nxt;
      last_time_r  <= last_time_nxt;
    end
  end

  // Result stage: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_space) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dist_r      <= out_dist_nxt;
      out_status_r    <= out_status_nxt;
      out_need_init_r <= !init_flag_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_mm = out_dist_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.need_init   = out_need_init_r;

endmodule

[sim/rsq_result_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range sample qualifier result monitor
// Watches the poll, result and register channels, predicts each qualified
// result and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module rsq_result_monitor (
  input  logic        clk,
  input  logic        rst_n,
  rsq_in_if           in_mon,
  rsq_out_if          out_mon,
  rsq_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned pending
);
  import rsq_pkg::*;

  typedef struct packed {
    logic  init_done;
    byte_t irq;
    byte_t rstat;
    dist_t raw;
    time_t now;
  } poll_t;

  typedef struct packed {
    dist_t       dist_mm;
    rsq_status_t status;
    logic        need_init;
  } qual_t;

  // Register copies
  dist_t  min_mm;
  dist_t  max_mm;
  stale_t stale_lim;

  // Qualifier state
  logic   armed;
  logic   sample_held;
  dist_t  held_mm;
  time_t  fresh_stamp;

  qual_t       qual_q[$];
  int unsigned n_fail = 0;

  assign mismatches = n_fail;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  // Minimum first, then maximum, so a crossed pair ends on the maximum
  function automatic dist_t clamp_mm(input dist_t mm);
    dist_t v;
    v = mm;
    if (min_mm != '0 && v < min_mm) v = min_mm;
    if (max_mm != '0 && v > max_mm) v = max_mm;
    return v;
  endfunction

  function automatic qual_t qualify_poll(input poll_t p);
    qual_t      q;
    logic [3:0] dev;
    time_t      age;
    q.dist_mm = '0;
    q.status  = ST_OK;
    dev       = p.rstat[6:3];
    if (p.init_done) begin
      armed       = 1'b1;
      sample_held = 1'b0;
    end
    if (!armed) begin
      q.status = ST_NOT_READY;
    end else if ((p.irq[2:0] & IrqNewMask) != '0) begin
      if (p.raw == '0) begin
        armed    = sample_held;
        q.status = ST_INVALID;
      end else begin
        held_mm = clamp_mm((dev == DevStatusGood || dev == DevStatusSigma ||
                            dev == DevStatusWrap) ? p.raw : OutOfRangeMm);
        sample_held = 1'b1;
        fresh_stamp = p.now;
        q.dist_mm   = held_mm;
      end
    end else if (!sample_held) begin
      q.status = ST_NOT_READY;
    end else begin
      age = p.now - fresh_stamp;
      if (age > time_t'(stale_lim)) begin
        armed       = 1'b0;
        sample_held = 1'b0;
        q.status    = ST_STALE;
      end else begin
        q.dist_mm = held_mm;
      end
    end
    q.need_init = !armed;
    return q;
  endfunction

  always @(posedge clk) begin
    qual_t want;
    if (!rst_n) begin
      min_mm      <= '0;
      max_mm      <= '0;
      stale_lim   <= StaleResetUs;
      armed       <= 1'b0;
      sample_held <= 1'b0;
      held_mm     <= '0;
      fresh_stamp <= '0;
      qual_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_MIN_DIST:  min_mm    = cfg_mon.data[DistW-1:0];
          CFG_MAX_DIST:  max_mm    = cfg_mon.data[DistW-1:0];
          CFG_STALE_LIM: stale_lim = cfg_mon.data[StaleW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        qual_q.push_back(qualify_poll({in_mon.init_done, in_mon.irq_status,
                                       in_mon.range_status, in_mon.raw_distance,
                                       in_mon.now_us}));
      if (out_mon.valid && out_mon.ready) begin
        if (qual_q.size() == 0) begin
          report_mismatch("unexpected result", out_mon.distance_mm, 0);
        end else begin
          want = qual_q.pop_front();
          if (out_mon.distance_mm !== want.dist_mm)
            report_mismatch("distance_mm", out_mon.distance_mm, want.dist_mm);
          if (out_mon.status !== want.status)
            report_mismatch("status", out_mon.status, want.status);
          if (out_mon.need_init !== want.need_init)
            report_mismatch("need_init", out_mon.need_init, want.need_init);
        end
      end
    end
    pending <= qual_q.size();
  end

endmodule

[sim/tb_range_sample_qualifier_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range sample qualifier testbench
// Drives directed and random sensor polls through the unit over several
// register settings, with random idling on both channels and one long result
// hold-off; the result monitor predicts and checks every beat.
// ----------------------------------------------------------------------------
module tb_range_sample_qualifier_unit;
  import rsq_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 9;
  localparam int PhaseCount    = 6;
  localparam int PollsPerPhase = 117;
  localparam int SettleCycles  = 4;    // two pipeline stages plus margin
  localparam int HoldOffCycles = 96;
  localparam int WatchdogLimit = 2000;

  logic clk = 1'b0;
  logic rst_n;

  always #(ClkPeriod / 2) clk = ~clk;

  rsq_in_if  in_ch ();
  rsq_out_if out_ch ();
  rsq_cfg_if cfg_ch ();

  range_sample_qualifier_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int unsigned n_mismatch;
  int unsigned n_pending;

  rsq_result_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (n_mismatch),
    .pending    (n_pending)
  );

  // Shared between the poll source and the result sink
  logic        idle_on = 1'b1;     // random idling on both channels
  int unsigned squeeze_req = 0;    // bump to make the sink hold off

  // Stimulus-side view of time: last poll time, last fresh sample time, and
  // the stale limit currently programmed (used to aim at the boundary)
  time_t  clock_us;
  time_t  fresh_us;
  stale_t stale_cfg;
  logic   reinit_next;

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on any channel for too long
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure, plus a long hold-off on request so the
  // pipeline fills and the poll channel stalls
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    int unsigned squeeze_seen;
    hold         = 0;
    squeeze_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        hold         = HoldOffCycles;
      end
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 34);
      end
    end
  end

  // Range status byte with the given device status in bits 6..3
  function automatic byte_t rstat_of(input logic [3:0] dev, input logic [3:0] pad);
    return {pad[3], dev, pad[2:0]};
  endfunction

  // Offer one poll and hold it until the unit takes the beat. Idle cycles go
  // in front of the beat; valid is never dropped between back-to-back beats.
  task automatic send_poll(input logic ini, input byte_t irq, input byte_t rs,
                           input dist_t raw, input time_t now);
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.init_done    <= ini;
    in_ch.irq_status   <= irq;
    in_ch.range_status <= rs;
    in_ch.raw_distance <= raw;
    in_ch.now_us       <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // One register write beat; the caller drops valid after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Drop the poll valid and wait for every outstanding result to come back,
  // then let the pipeline settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random poll. Mostly a well-behaved controller: fresh samples with advancing
  // time, repeat polls aimed around the stale boundary, and usually a
  // re-initialisation after an error. The rest is noise.
  // --------------------------------------------------------------------------
  task automatic random_poll();
    logic       ini;
    byte_t      irq;
    byte_t      rs;
    dist_t      raw;
    time_t      now;
    logic [3:0] dev;
    int         kind;
    int         pick;
    ini  = reinit_next ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 4);
    reinit_next = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // fresh sample: irq low bits nonzero, mostly accepted device status
      irq = byte_t'($urandom);
      if (irq[2:0] == '0) irq[2:0] = 3'($urandom_range(1, 7));
      pick = $urandom_range(0, 9);
      if (pick < 3)      dev = DevStatusGood;
      else if (pick < 5) dev = DevStatusSigma;
      else if (pick < 7) dev = DevStatusWrap;
      else               dev = 4'($urandom);
      rs   = rstat_of(dev, 4'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 8)       raw = '0;
      else if (pick < 50) raw = dist_t'($urandom_range(1, 10000));
      else                raw = dist_t'($urandom);
      now = clock_us + time_t'($urandom_range(0, 2000));
      if (raw == '0) reinit_next = 1'b1;
    end else if (kind < 95) begin
      // repeat poll: no new sample, age chosen around the stale limit
      irq = byte_t'($urandom) & ~{5'b0, IrqNewMask};
      rs  = byte_t'($urandom);
      raw = dist_t'($urandom);
      case ($urandom_range(0, 4))
        0: now = fresh_us;
        1: now = fresh_us + time_t'(stale_cfg);
        2: begin
          now = fresh_us + time_t'(stale_cfg) + 1;
          reinit_next = 1'b1;
        end
        3: now = fresh_us + time_t'($urandom_range(0, stale_cfg));
        default: begin
          now = fresh_us + time_t'({$urandom, $urandom});
          reinit_next = 1'b1;
        end
      endcase
    end else begin
      // noise: everything random, time included
      irq = byte_t'($urandom);
      rs  = byte_t'($urandom);
      raw = dist_t'($urandom);
      now = time_t'({$urandom, $urandom});
      reinit_next = 1'b1;
    end
    clock_us = now;
    if (irq[2:0] != '0 && raw != '0) fresh_us = now;
    send_poll(ini, irq, rs, raw, now);
  endtask

  // Program all three registers for a phase; phase 0 keeps the reset values
  task automatic program_phase(input int ph);
    dist_t  lo;
    dist_t  hi;
    stale_t lim;
    case (ph)
      1: begin lo = 16'hFFFF; hi = 16'h0000; lim = 24'd0;        end
      2: begin lo = 16'h0000; hi = 16'hFFFF; lim = 24'hFFFFFF;   end
      3: begin lo = 16'd3000; hi = 16'd1000; lim = 24'd500;      end  // crossed
      4: begin lo = 16'd200;  hi = 16'd9000; lim = 24'd100000;   end
      default: begin lo = 16'd1; hi = 16'd1; lim = 24'd1;        end
    endcase
    write_reg(CFG_MIN_DIST, CfgDataW'(lo));
    write_reg(CFG_MAX_DIST, CfgDataW'(hi));
    write_reg(CFG_STALE_LIM, lim);
    cfg_ch.valid <= 1'b0;
    stale_cfg = lim;
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : poll_source
    time_t t0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.init_done    <= 1'b0;
    in_ch.irq_status   <= '0;
    in_ch.range_status <= '0;
    in_ch.raw_distance <= '0;
    in_ch.now_us       <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_MIN_DIST;
    cfg_ch.data        <= '0;
    stale_cfg   = StaleResetUs;
    reinit_next = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls under reset settings (stale limit 1000000 us)
    t0 = 48'h1000;
    // not initialised: both a plain poll and a sample poll leave state alone
    send_poll(1'b0, 8'h00, rstat_of(DevStatusGood, 4'h0), 16'd100, t0);
    send_poll(1'b0, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd100, t0);
    // init done with no sample yet
    send_poll(1'b1, 8'h00, 8'h00, 16'd0, t0);
    // each accepted device status, distance extremes
    send_poll(1'b0, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd1234, t0 + 10);
    send_poll(1'b0, 8'hF8, rstat_of(DevStatusGood, 4'h0), 16'd999, t0 + 20);
    send_poll(1'b0, 8'h02, rstat_of(DevStatusSigma, 4'hF), 16'hFFFF, t0 + 30);
    send_poll(1'b0, 8'h04, rstat_of(DevStatusWrap, 4'h0), 16'd1, t0 + 40);
    // rejected device status substitutes the out-of-range value
    send_poll(1'b0, 8'h07, rstat_of(4'h0, 4'h0), 16'd500, t0 + 50);
    // zero distance on a sample: invalid, cache kept
    send_poll(1'b0, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd0, t0 + 60);
    // stale boundary: exactly the limit holds, one past it times out
    send_poll(1'b0, 8'h00, 8'h00, 16'd0, t0 + 50 + 48'(StaleResetUs));
    send_poll(1'b0, 8'h00, 8'h00, 16'd0, t0 + 51 + 48'(StaleResetUs));
    send_poll(1'b0, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd77, t0 + 60);
    // zero distance straight after init: no cache, so init flag drops
    send_poll(1'b1, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd0, t0 + 70);
    // time wraps through 2^48
    send_poll(1'b1, 8'h01, rstat_of(DevStatusGood, 4'h0), 16'd7, 48'hFFFF_FFFF_FFFF);
    send_poll(1'b0, 8'h00, 8'hFF, 16'd0, 48'd5);
    // re-init while already initialised clears the cache
    send_poll(1'b1, 8'h00, 8'h00, 16'd0, 48'd6);
    send_poll(1'b0, 8'hFF, 8'hFF, 16'hFFFF, 48'd7);
    send_poll(1'b0, 8'h00, 8'h00, 16'd0, 48'd7);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        drain_results();
        program_phase(ph);
      end
      // idle-free stretch in phase 2, where the sink also holds off once
      idle_on     = (ph != 2);
      clock_us    = time_t'({$urandom, $urandom});
      fresh_us    = clock_us;
      reinit_next = 1'b1;
      for (int n = 0; n < PollsPerPhase; n++) begin
        if (ph == 2 && n == 20) squeeze_req++;
        random_poll();
      end
    end

    drain_results();
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
